// ===== hdl/r2q_pkg.sv =====
// Shared constants, branch codes and types for the matrix-to-quaternion block.
package r2q_pkg;

   localparam int FRAC_BITS   = 14;
   localparam int DATA_W      = 16;
   // Radicand after clamping: below 7 * 2^FRAC_BITS.
   localparam int RAD_W       = FRAC_BITS + 3;
   // Sum or difference of two matrix elements.
   localparam int NUM_W       = DATA_W + 1;
   // floor(sqrt(rad << FRAC_BITS)) fits in half the width of the shifted radicand.
   localparam int ROOT_W      = (RAD_W + FRAC_BITS + 1) / 2;
   localparam int SQRT_STAGES = ROOT_W;
   // One operand-prep stage plus one stage per quotient bit.
   localparam int DIV_STAGES  = DATA_W + 1;
   // Square root stages, divider stages, output register.
   localparam int BACK_LAT    = SQRT_STAGES + DIV_STAGES + 1;
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_AW     = 2;

   localparam logic [1:0] BR_TRACE = 2'd0;
   localparam logic [1:0] BR_X     = 2'd1;
   localparam logic [1:0] BR_Y     = 2'd2;
   localparam logic [1:0] BR_Z     = 2'd3;

   localparam logic signed [DATA_W-1:0] QMAX = 16'sh7fff;
   localparam logic signed [DATA_W-1:0] QMIN = 16'sh8000;

   // Classified request: branch, clamped radicand and the three divided numerators,
   // listed in w, x, y, z order with the branch's own component left out.
   typedef struct packed {
      logic [1:0]              branch;
      logic                    rad_err;
      logic [RAD_W-1:0]        rad;
      logic signed [NUM_W-1:0] num0;
      logic signed [NUM_W-1:0] num1;
      logic signed [NUM_W-1:0] num2;
   } work_type;

endpackage

// ===== hdl/r2q_front.sv =====
// Front end: accepts a matrix, picks the branch and forms radicand and numerators.
module r2q_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2 from bit 0 up
   input  logic [143:0]          req_tdata,
   output logic                  out_valid,
   input  logic                  out_ready,
   output r2q_pkg::work_type     out_work
);

   logic signed [r2q_pkg::DATA_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
   logic signed [r2q_pkg::DATA_W+1:0] trace;
   logic signed [r2q_pkg::DATA_W+1:0] rad;
   logic signed [r2q_pkg::NUM_W-1:0]  nw, nx, ny, s01, s02, s12;
   logic [1:0]                        branch;
   r2q_pkg::work_type                 work_in, work_ff;
   logic                              valid_in, valid_ff;

   assign m00 = req_tdata[15:0];
   assign m01 = req_tdata[31:16];
   assign m02 = req_tdata[47:32];
   assign m10 = req_tdata[63:48];
   assign m11 = req_tdata[79:64];
   assign m12 = req_tdata[95:80];
   assign m20 = req_tdata[111:96];
   assign m21 = req_tdata[127:112];
   assign m22 = req_tdata[143:128];

   // Branch choice and radicand
   always_comb begin
      trace = 18'(m00) + 18'(m11) + 18'(m22);
      if (trace > 0) begin
         branch = r2q_pkg::BR_TRACE;
         rad    = 18'sd16384 + trace;
      end else if (m00 > m11 && m00 > m22) begin
         branch = r2q_pkg::BR_X;
         rad    = 18'sd16384 + 18'(m00) - 18'(m11) - 18'(m22);
      end else if (m11 > m22) begin
         branch = r2q_pkg::BR_Y;
         rad    = 18'sd16384 + 18'(m11) - 18'(m00) - 18'(m22);
      end else begin
         branch = r2q_pkg::BR_Z;
         rad    = 18'sd16384 + 18'(m22) - 18'(m00) - 18'(m11);
      end
   end

   // Numerators
   assign nw  = 17'(m21) - 17'(m12);
   assign nx  = 17'(m02) - 17'(m20);
   assign ny  = 17'(m10) - 17'(m01);
   assign s01 = 17'(m01) + 17'(m10);
   assign s02 = 17'(m02) + 17'(m20);
   assign s12 = 17'(m12) + 17'(m21);

   always_comb begin
      work_in.branch  = branch;
      work_in.rad_err = rad[r2q_pkg::DATA_W+1];
      work_in.rad     = rad[r2q_pkg::DATA_W+1] ? '0 : rad[r2q_pkg::RAD_W-1:0];
      unique case (branch)
         r2q_pkg::BR_TRACE: begin
            work_in.num0 = nw;
            work_in.num1 = nx;
            work_in.num2 = ny;
         end
         r2q_pkg::BR_X: begin
            work_in.num0 = nw;
            work_in.num1 = s01;
            work_in.num2 = s02;
         end
         r2q_pkg::BR_Y: begin
            work_in.num0 = nx;
            work_in.num1 = s01;
            work_in.num2 = s12;
         end
         default: begin
            work_in.num0 = ny;
            work_in.num1 = s02;
            work_in.num2 = s12;
         end
      endcase
   end

   // Holding register toward the queue
   assign req_tready = !valid_ff || out_ready;
   assign valid_in   = (req_tvalid && req_tready) || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

// ===== hdl/r2q_fifo.sv =====
// Short queue between front end and back end.
module r2q_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  r2q_pkg::work_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output r2q_pkg::work_type pop_data
);

   r2q_pkg::work_type            store_ff [r2q_pkg::FIFO_DEPTH];
   logic [r2q_pkg::FIFO_AW-1:0]  wptr_ff, rptr_ff;
   logic [r2q_pkg::FIFO_AW:0]    count_ff, count_in;
   logic                         push, pop;

   assign push_ready = count_ff != (r2q_pkg::FIFO_AW+1)'(r2q_pkg::FIFO_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = store_ff[rptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wptr_ff <= wptr_ff + 1'b1;
         end
         if (pop) begin
            rptr_ff <= rptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wptr_ff] <= push_data;
      end
   end

   // Fill level stays within the storage
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (r2q_pkg::FIFO_AW+1)'(r2q_pkg::FIFO_DEPTH))
      else $error("queue fill level out of range");

   // Level rises by one after a push without a pop
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue level did not follow push");

endmodule

// ===== hdl/r2q_sqrt.sv =====
// Pipelined integer square root of (rad << FRAC_BITS), one result bit per stage.
module r2q_sqrt (
   input  logic                         clock,
   input  logic                         en,
   input  logic [r2q_pkg::RAD_W-1:0]    rad_in,
   output logic [r2q_pkg::ROOT_W-1:0]   root_out
);

   localparam int X_W   = 2 * r2q_pkg::ROOT_W;
   localparam int REM_W = r2q_pkg::ROOT_W + 3;
   localparam int N     = r2q_pkg::SQRT_STAGES;

   logic [X_W-1:0]              x_ff    [N];
   logic [REM_W-1:0]            rem_ff  [N];
   logic [r2q_pkg::ROOT_W-1:0]  root_ff [N];
   logic [X_W-1:0]              x_in    [N];
   logic [REM_W-1:0]            rem_in  [N];
   logic [r2q_pkg::ROOT_W-1:0]  root_in [N];
   logic [X_W-1:0]              src_x   [N];
   logic [REM_W-1:0]            src_rem [N];
   logic [r2q_pkg::ROOT_W-1:0]  src_root[N];
   logic [REM_W-1:0]            rem2    [N];
   logic [REM_W-1:0]            trial   [N];

   // One restoring step per stage
   always_comb begin
      for (int k = 0; k < N; k++) begin
         if (k == 0) begin
            src_x[k]    = X_W'(rad_in) << r2q_pkg::FRAC_BITS;
            src_rem[k]  = '0;
            src_root[k] = '0;
         end else begin
            src_x[k]    = x_ff[k-1];
            src_rem[k]  = rem_ff[k-1];
            src_root[k] = root_ff[k-1];
         end
         rem2[k]  = {src_rem[k][REM_W-3:0], src_x[k][X_W-1 -: 2]};
         trial[k] = {1'b0, src_root[k], 2'b01};
         x_in[k]  = src_x[k] << 2;
         if (rem2[k] >= trial[k]) begin
            rem_in[k]  = rem2[k] - trial[k];
            root_in[k] = {src_root[k][r2q_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = rem2[k];
            root_in[k] = {src_root[k][r2q_pkg::ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < N; k++) begin
            x_ff[k]    <= x_in[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
      end
   end

   assign root_out = root_ff[N-1];

endmodule

// ===== hdl/r2q_div.sv =====
// Pipelined rounded divide num * ONE / (2 * root) with saturation to 16 bits.
module r2q_div (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [r2q_pkg::NUM_W-1:0]   num,
   input  logic [r2q_pkg::ROOT_W-1:0]         root,
   output logic signed [r2q_pkg::DATA_W-1:0]  value,
   output logic                               sat
);

   localparam int N     = r2q_pkg::DIV_STAGES;
   localparam int Q_W   = r2q_pkg::DATA_W;
   localparam int S_W   = r2q_pkg::ROOT_W + 1;
   localparam int DD_W  = 2 * Q_W;

   logic [S_W-1:0]   s_ff    [N];
   logic [S_W-1:0]   rem_ff  [N];
   logic [Q_W-1:0]   lo_ff   [N];
   logic [Q_W-1:0]   q_ff    [N];
   logic             neg_ff  [N];
   logic             znum_ff [N];
   logic             zdiv_ff [N];
   logic             ovf_ff  [N];
   logic [S_W-1:0]   rem_in  [N];
   logic [Q_W-1:0]   lo_in   [N];
   logic [Q_W-1:0]   q_in    [N];
   logic [S_W:0]     r2      [N];
   logic [r2q_pkg::NUM_W-1:0] mag;
   logic [DD_W-1:0]  dividend;
   logic             ovf0;
   logic [Q_W-1:0]   qv;

   // Operand prep: rounded dividend and quotient range check
   always_comb begin
      mag      = num[r2q_pkg::NUM_W-1] ? r2q_pkg::NUM_W'(-num) : r2q_pkg::NUM_W'(num);
      dividend = (DD_W'(mag) << r2q_pkg::FRAC_BITS) + DD_W'(root);
      ovf0     = {1'b0, dividend} >= ((DD_W+1)'(root) << (Q_W + 1));
   end

   // Quotient steps, one bit per stage
   always_comb begin
      for (int k = 0; k < N; k++) begin
         r2[k]     = '0;
         rem_in[k] = '0;
         lo_in[k]  = '0;
         q_in[k]   = '0;
         if (k > 0) begin
            r2[k]    = {rem_ff[k-1], lo_ff[k-1][Q_W-1]};
            lo_in[k] = lo_ff[k-1] << 1;
            if (r2[k] >= {1'b0, s_ff[k-1]}) begin
               rem_in[k] = S_W'(r2[k] - {1'b0, s_ff[k-1]});
               q_in[k]   = {q_ff[k-1][Q_W-2:0], 1'b1};
            end else begin
               rem_in[k] = S_W'(r2[k]);
               q_in[k]   = {q_ff[k-1][Q_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff[0]    <= {root, 1'b0};
         rem_ff[0]  <= S_W'(dividend[DD_W-1:Q_W]);
         lo_ff[0]   <= dividend[Q_W-1:0];
         q_ff[0]    <= '0;
         neg_ff[0]  <= num[r2q_pkg::NUM_W-1];
         znum_ff[0] <= num == '0;
         zdiv_ff[0] <= root == '0;
         ovf_ff[0]  <= ovf0;
         for (int k = 1; k < N; k++) begin
            s_ff[k]    <= s_ff[k-1];
            rem_ff[k]  <= rem_in[k];
            lo_ff[k]   <= lo_in[k];
            q_ff[k]    <= q_in[k];
            neg_ff[k]  <= neg_ff[k-1];
            znum_ff[k] <= znum_ff[k-1];
            zdiv_ff[k] <= zdiv_ff[k-1];
            ovf_ff[k]  <= ovf_ff[k-1];
         end
      end
   end

   // Sign, zero divisor and saturation
   assign qv = q_ff[N-1];

   always_comb begin
      if (zdiv_ff[N-1]) begin
         sat   = 1'b1;
         value = znum_ff[N-1] ? '0 : (neg_ff[N-1] ? r2q_pkg::QMIN : r2q_pkg::QMAX);
      end else if (ovf_ff[N-1]) begin
         sat   = 1'b1;
         value = neg_ff[N-1] ? r2q_pkg::QMIN : r2q_pkg::QMAX;
      end else if (!neg_ff[N-1]) begin
         sat   = qv[Q_W-1];
         value = qv[Q_W-1] ? r2q_pkg::QMAX : $signed(qv);
      end else begin
         sat   = qv > 16'h8000;
         value = (qv > 16'h8000) ? r2q_pkg::QMIN : $signed(Q_W'(-{1'b0, qv}));
      end
   end

endmodule

// ===== hdl/r2q_back.sv =====
// Back end: square root, three dividers and the output register.
module r2q_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  r2q_pkg::work_type   in_work,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // quat_w, quat_x, quat_y, quat_z from bit 0 up
   output logic [63:0]         rsp_tdata,
   // branch_taken, error_flag from bit 0 up
   output logic [2:0]          rsp_tuser
);

   localparam int SQ  = r2q_pkg::SQRT_STAGES;
   localparam int DV  = r2q_pkg::DIV_STAGES;
   localparam int LAT = r2q_pkg::BACK_LAT;

   logic                               en;
   logic                               valid_ff [LAT];
   r2q_pkg::work_type                  work_ff  [SQ];
   logic [1:0]                         br_ff    [DV];
   logic                               rerr_ff  [DV];
   logic [r2q_pkg::ROOT_W-1:0]         root_ff  [DV];
   logic [r2q_pkg::ROOT_W-1:0]         root;
   logic signed [r2q_pkg::DATA_W-1:0]  d0, d1, d2, own;
   logic                               sat0, sat1, sat2;
   logic signed [r2q_pkg::DATA_W-1:0]  w_ff, x_ff, y_ff, z_ff;
   logic signed [r2q_pkg::DATA_W-1:0]  w_in, x_in, y_in, z_in;
   logic [1:0]                         br_out_ff;
   logic                               err_ff, err_in;

   // Whole pipeline advances unless the output is held
   assign en       = !valid_ff[LAT-1] || rsp_tready;
   assign in_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < LAT; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   r2q_sqrt u_sqrt (
      .clock    (clock),
      .en       (en),
      .rad_in   (in_work.rad),
      .root_out (root)
   );

   r2q_div u_div0 (.clock(clock), .en(en), .num(work_ff[SQ-1].num0), .root(root),
                   .value(d0), .sat(sat0));
   r2q_div u_div1 (.clock(clock), .en(en), .num(work_ff[SQ-1].num1), .root(root),
                   .value(d1), .sat(sat1));
   r2q_div u_div2 (.clock(clock), .en(en), .num(work_ff[SQ-1].num2), .root(root),
                   .value(d2), .sat(sat2));

   // Side data riding alongside the arithmetic
   always_ff @(posedge clock) begin
      if (en) begin
         work_ff[0] <= in_work;
         for (int k = 1; k < SQ; k++) begin
            work_ff[k] <= work_ff[k-1];
         end
         br_ff[0]   <= work_ff[SQ-1].branch;
         rerr_ff[0] <= work_ff[SQ-1].rad_err;
         root_ff[0] <= root;
         for (int k = 1; k < DV; k++) begin
            br_ff[k]   <= br_ff[k-1];
            rerr_ff[k] <= rerr_ff[k-1];
            root_ff[k] <= root_ff[k-1];
         end
      end
   end

   // Place own and divided components
   assign own    = $signed({1'b0, root_ff[DV-1][r2q_pkg::ROOT_W-1:1]});
   assign err_in = rerr_ff[DV-1] || sat0 || sat1 || sat2;

   always_comb begin
      unique case (br_ff[DV-1])
         r2q_pkg::BR_TRACE: begin
            w_in = own; x_in = d0;  y_in = d1;  z_in = d2;
         end
         r2q_pkg::BR_X: begin
            w_in = d0;  x_in = own; y_in = d1;  z_in = d2;
         end
         r2q_pkg::BR_Y: begin
            w_in = d0;  x_in = d1;  y_in = own; z_in = d2;
         end
         default: begin
            w_in = d0;  x_in = d1;  y_in = d2;  z_in = own;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_ff      <= w_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
         z_ff      <= z_in;
         br_out_ff <= br_ff[DV-1];
         err_ff    <= err_in;
      end
   end

   assign rsp_tvalid = valid_ff[LAT-1];
   assign rsp_tdata  = {z_ff, y_ff, x_ff, w_ff};
   assign rsp_tuser  = {err_ff, br_out_ff};

   // The component taken from the root is never negative
   a_own_nonneg: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && br_out_ff == r2q_pkg::BR_TRACE) |-> !w_ff[r2q_pkg::DATA_W-1])
      else $error("trace branch gave negative w");

   // A clamped radicand always reaches the error flag
   a_rad_err: assert property (@(posedge clock) disable iff (reset)
      (en && valid_ff[LAT-2] && rerr_ff[DV-1]) |=> err_ff)
      else $error("clamped radicand lost its error flag");

endmodule

// ===== hdl/rotation_matrix_to_quaternion.sv =====
// Top level: rotation matrix in, unit quaternion out, Shepperd branch selection.
//
// Converts one 3x3 rotation matrix (Q2.14) per clock into a quaternion (Q2.14)
// with the branch taken and an error flag. A request is classified in the front
// register, waits in a four-entry queue, then runs through a 16-stage pipelined
// square root (one root bit per stage) and three parallel 17-stage dividers ending
// in the output register. Throughput is one request per cycle, set by the fully
// pipelined root and divide units; a held response stalls the back end and the
// queue absorbs the front end.
module rotation_matrix_to_quaternion (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2 from bit 0 up
   input  logic [143:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // quat_w, quat_x, quat_y, quat_z from bit 0 up
   output logic [63:0]   rsp_tdata,
   // branch_taken, error_flag from bit 0 up
   output logic [2:0]    rsp_tuser
);

   r2q_pkg::work_type front_work, queue_work;
   logic              front_valid, front_ready;
   logic              queue_valid, queue_ready;

   r2q_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .out_valid  (front_valid),
      .out_ready  (front_ready),
      .out_work   (front_work)
   );

   r2q_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_work),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_work)
   );

   r2q_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (queue_valid),
      .in_ready   (queue_ready),
      .in_work    (queue_work),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== verif/tb_top.sv =====
// Testbench for the rotation-matrix-to-quaternion converter with a self-checking predictor.
`timescale 1ns / 1ps

// Expected quaternion results, one per accepted request, checked in order.
class quat_scoreboard;
   logic [66:0] pending[$];
   int          mismatches;

   // floor(sqrt(x)), bit by bit
   static function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   static function automatic longint clip16(longint v, ref bit err);
      if (v > 32767) begin
         err = 1;
         return 32767;
      end
      if (v < -32768) begin
         err = 1;
         return -32768;
      end
      return v;
   endfunction

   // numerator / S, rounded half away from zero, saturated
   static function automatic longint scaled_div(longint num, longint unsigned s, ref bit err);
      longint unsigned mag;
      longint unsigned q;
      if (s == 0) begin
         err = 1;
         return (num > 0) ? 32767 : ((num < 0) ? -32768 : 0);
      end
      mag = (num < 0) ? -num : num;
      q = ((mag << r2q_pkg::FRAC_BITS) + (s >> 1)) / s;
      if (q > (64'd1 << 40)) q = 64'd1 << 40;
      return clip16((num < 0) ? -longint'(q) : longint'(q), err);
   endfunction

   function void note_request(logic [143:0] d);
      longint m[9];
      longint one, tr, rad, own, qw, qx, qy, qz;
      longint unsigned root, s;
      logic [1:0] br;
      bit err;
      logic [15:0] w16, x16, y16, z16;
      for (int i = 0; i < 9; i++) m[i] = longint'($signed(d[16*i +: 16]));
      one = 64'sd1 << r2q_pkg::FRAC_BITS;
      tr = m[0] + m[4] + m[8];
      err = 0;
      if (tr > 0) begin
         br = r2q_pkg::BR_TRACE;
         rad = one + tr;
      end else if (m[0] > m[4] && m[0] > m[8]) begin
         br = r2q_pkg::BR_X;
         rad = one + m[0] - m[4] - m[8];
      end else if (m[4] > m[8]) begin
         br = r2q_pkg::BR_Y;
         rad = one + m[4] - m[0] - m[8];
      end else begin
         br = r2q_pkg::BR_Z;
         rad = one + m[8] - m[0] - m[4];
      end
      if (rad < 0) begin
         rad = 0;
         err = 1;
      end
      root = int_sqrt(longint'(rad) << r2q_pkg::FRAC_BITS);
      s = root << 1;
      own = clip16(longint'(root >> 1), err);
      case (br)
         r2q_pkg::BR_TRACE: begin
            qw = own;
            qx = scaled_div(m[7] - m[5], s, err);
            qy = scaled_div(m[2] - m[6], s, err);
            qz = scaled_div(m[3] - m[1], s, err);
         end
         r2q_pkg::BR_X: begin
            qw = scaled_div(m[7] - m[5], s, err);
            qx = own;
            qy = scaled_div(m[1] + m[3], s, err);
            qz = scaled_div(m[2] + m[6], s, err);
         end
         r2q_pkg::BR_Y: begin
            qw = scaled_div(m[2] - m[6], s, err);
            qx = scaled_div(m[1] + m[3], s, err);
            qy = own;
            qz = scaled_div(m[5] + m[7], s, err);
         end
         default: begin
            qw = scaled_div(m[3] - m[1], s, err);
            qx = scaled_div(m[2] + m[6], s, err);
            qy = scaled_div(m[5] + m[7], s, err);
            qz = own;
         end
      endcase
      w16 = qw[15:0];
      x16 = qx[15:0];
      y16 = qy[15:0];
      z16 = qz[15:0];
      pending.push_back({err, br, z16, y16, x16, w16});
   endfunction

   function void check_response(logic [63:0] d, logic [2:0] u);
      logic [66:0] e;
      if (pending.size() == 0) begin
         $error("unexpected response data=%h user=%h", d, u);
         mismatches++;
         return;
      end
      e = pending.pop_front();
      if (d[15:0] !== e[15:0]) begin
         $error("quat_w exp %h got %h", e[15:0], d[15:0]);
         mismatches++;
      end
      if (d[31:16] !== e[31:16]) begin
         $error("quat_x exp %h got %h", e[31:16], d[31:16]);
         mismatches++;
      end
      if (d[47:32] !== e[47:32]) begin
         $error("quat_y exp %h got %h", e[47:32], d[47:32]);
         mismatches++;
      end
      if (d[63:48] !== e[63:48]) begin
         $error("quat_z exp %h got %h", e[63:48], d[63:48]);
         mismatches++;
      end
      if (u[1:0] !== e[65:64]) begin
         $error("branch_taken exp %0d got %0d", e[65:64], u[1:0]);
         mismatches++;
      end
      if (u[2] !== e[66]) begin
         $error("error_flag exp %0d got %0d", e[66], u[2]);
         mismatches++;
      end
   endfunction
endclass

module tb_top;
   localparam int LIMIT = 600000;

   logic          clock = 0;
   logic          reset = 1;
   logic          req_tvalid = 0;
   logic          req_tready;
   logic [143:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 0;
   logic [63:0]   rsp_tdata;
   logic [2:0]    rsp_tuser;

   quat_scoreboard quats = new();
   int  cycles = 0;
   bit  sending_done = 0;

   rotation_matrix_to_quaternion dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // gap length: mostly short, now and then long
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 45) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // random element biased toward rotation-like values and the extremes
   function automatic logic [15:0] rand_elem();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'(32'h4000 + $urandom_range(0, 64) - 32);
         3: return 16'(32'hc000 + $urandom_range(0, 64) - 32);
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   // rotation matrix from a random unit quaternion
   function automatic logic [143:0] rand_rotation();
      real a, b, c, d, n;
      real r[9];
      logic [143:0] v;
      a = $urandom_range(0, 2000) - 1000.0;
      b = $urandom_range(0, 2000) - 1000.0;
      c = $urandom_range(0, 2000) - 1000.0;
      d = $urandom_range(0, 2000) - 1000.0;
      n = $sqrt(a*a + b*b + c*c + d*d);
      if (n < 1.0) begin
         a = 1.0;
         n = 1.0;
      end
      a = a / n; b = b / n; c = c / n; d = d / n;
      r[0] = 1 - 2*(c*c + d*d); r[1] = 2*(b*c - a*d); r[2] = 2*(b*d + a*c);
      r[3] = 2*(b*c + a*d); r[4] = 1 - 2*(b*b + d*d); r[5] = 2*(c*d - a*b);
      r[6] = 2*(b*d - a*c); r[7] = 2*(c*d + a*b); r[8] = 1 - 2*(b*b + c*c);
      for (int i = 0; i < 9; i++)
         v[16*i +: 16] = 16'($rtoi(r[i] * 16384.0) + $urandom_range(0, 6) - 3);
      return v;
   endfunction

   // valid stays up between back-to-back requests; it drops only for a gap
   task automatic send_request(logic [143:0] d);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      quats.note_request(d);
   endtask

   // stop sending and wait for every expected response
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (quats.pending.size() != 0) @(posedge clock);
   endtask

   task automatic send_diag(int a, int b, int c, logic [15:0] off);
      logic [143:0] v;
      for (int i = 0; i < 9; i++) v[16*i +: 16] = off + 16'(i * 37);
      v[15:0] = 16'(a);
      v[79:64] = 16'(b);
      v[143:128] = 16'(c);
      send_request(v);
   endtask

   // response side: random stalls, checks on each accepted result
   initial begin
      int g;
      @(negedge reset);
      forever begin
         g = gap_len();
         if (g > 0) begin
            rsp_tready <= 0;
            repeat (g) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         quats.check_response(rsp_tdata, rsp_tuser);
      end
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin
      logic [143:0] v;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // identity: trace branch
      send_diag(16384, 16384, 16384, 16'h0000);
      // each diagonal largest, and ties
      send_diag(16384, -16384, -16384, 16'h0100);
      send_diag(-16384, 16384, -16384, 16'h0200);
      send_diag(-16384, -16384, 16384, 16'h0300);
      send_diag(-16384, 0, 0, 16'h0010);
      send_diag(-100, -100, -200, 16'h0020);
      send_diag(-100, -100, -100, 16'h0030);
      // extreme diagonal values
      send_diag(-32768, -32768, -32768, 16'h7fff);
      send_diag(-32768, 32767, 32767, 16'h0000);
      // z branch, numerators of each sign
      send_diag(-16384, -16384, 0, 16'h0000);
      v = '0;
      v[15:0] = 16'(-16384); v[79:64] = 16'(-16384);
      v[47:32] = 16'h7fff; v[31:16] = 16'h8000; v[127:112] = 16'h8000;
      send_request(v);
      // all extremes
      send_request({9{16'h7fff}});
      send_request({9{16'h8000}});
      send_request({144{1'b1}});
      send_request('0);
      send_diag(1, 1, 1, 16'h7fff);
      send_diag(0, 0, 1, 16'h8000);
      for (int i = 0; i < 6; i++) send_request(rand_rotation());
      // drain once before the random part
      drain();
      for (int n = 0; n < 1900; n++) begin
         if (n == 950) drain();
         if ($urandom_range(0, 3) != 0) begin
            send_request(rand_rotation());
         end else begin
            for (int i = 0; i < 9; i++)
               v[16*i +: 16] = ($urandom_range(0, 1) != 0) ? rand_elem() : 16'($urandom);
            send_request(v);
         end
      end
      drain();
      repeat (80) @(posedge clock);
      if (quats.mismatches == 0 && quats.pending.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end
endmodule
